// ===== hw/rtl/pfwrl_pkg.sv =====
// Shared constants and types of the per-user fixed-window rate limiter.
package pfwrl_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned KEY_BITS      = 64;

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // "unknown" packed as ASCII, last character in the low byte
  localparam logic [63:0] RESERVED_KEY = 64'h0075_6E6B_6E6F_776E;

  localparam logic [31:0] MAX_REQ_RST = 32'd1000;
  localparam logic [31:0] WIN_SEC_RST = 32'd60;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_REQUESTS   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SECONDS = 1'b1;

  typedef logic [KEY_BITS-1:0] key_t;

  // count in the low half, window start in the high half
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] count;
  } entry_t;

endpackage

// ===== hw/rtl/per_user_fixed_window_rate_limiter.sv =====
// Per-user fixed-window rate limiter: table scan, counter update, output register.
// Flow: a request's key is compared with entries from 0 up in order; a match updates that
// entry, a new key is appended (untracked if the table is full); results wait for output.
// Throughput: one request at a time, set by the linear key scan through the key
// memory at one entry per cycle; the next request is taken once the result is registered.
// Reset: entry count cleared, registers to 1000 requests and 60 seconds; table memory is
// not cleared, since only entries below the entry count are read.
module per_user_fixed_window_rate_limiter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [63:0] user_key, [95:64] now_seconds
  input  logic [pfwrl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] user_present
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] allow, [32:1] window_count, [33] untracked, [39:34] zero
  output logic [pfwrl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [pfwrl_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [pfwrl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import pfwrl_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_MISS = 3'd3;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [31:0]       max_req_q, win_sec_q;
  key_t              key_q, key_d;
  logic [31:0]       now_q, now_d;

  // table memories
  key_t   key_mem [TABLE_ENTRIES];
  entry_t ent_mem [TABLE_ENTRIES];
  key_t   key_rd_q;
  entry_t ent_rd_q;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           ent_wdata;

  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic                  out_free;

  logic        last_entry;
  logic        table_full;
  logic        elapsed;
  logic [31:0] base_cnt, new_cnt, new_start;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign last_entry = (USED_W'(idx_q) + USED_W'(1)) == used_q;
  assign table_full = (used_q == USED_W'(TABLE_ENTRIES));

  // window update of a matched entry
  assign elapsed   = (now_q - ent_rd_q.start) >= win_sec_q;
  assign base_cnt  = elapsed ? 32'd0 : ent_rd_q.count;
  assign new_start = elapsed ? now_q : ent_rd_q.start;
  assign new_cnt   = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + 32'd1;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    used_d    = used_q;
    key_d     = key_q;
    now_d     = now_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    ent_wdata = '{start: new_start, count: new_cnt};
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;

    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (s_axis_tvalid) begin
          key_d   = s_axis_tuser ? s_axis_tdata[KEY_BITS-1:0] : RESERVED_KEY[KEY_BITS-1:0];
          now_d   = s_axis_tdata[95:64];
          state_d = (used_q == '0) ? ST_MISS : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (key_rd_q == key_q) begin
          state_d = ST_UPD;
        end else if (last_entry) begin
          state_d = ST_MISS;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_UPD: begin
        if (out_free) begin
          mem_we    = 1'b1;
          m_valid_d = 1'b1;
          m_data_d  = {6'd0, 1'b0, new_cnt, (new_cnt <= max_req_q)};
          state_d   = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
          if (table_full) begin
            m_data_d = {6'd0, 1'b1, 32'd0, 1'b1};
          end else begin
            // new entry: fresh window, first request counted
            mem_we    = 1'b1;
            mem_waddr = used_q[IDX_W-1:0];
            ent_wdata = '{start: now_q, count: 32'd1};
            used_d    = used_q + USED_W'(1);
            m_data_d  = {6'd0, 1'b0, 32'd1, (max_req_q != 32'd0)};
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ent_mem[mem_waddr] <= ent_wdata;
      if (state_q == ST_MISS) begin
        key_mem[mem_waddr] <= key_q;
      end
    end
    key_rd_q <= key_mem[idx_d];
    ent_rd_q <= ent_mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      used_q    <= '0;
      m_valid_q <= 1'b0;
      max_req_q <= MAX_REQ_RST;
      win_sec_q <= WIN_SEC_RST;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      used_q    <= used_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_MAX_REQUESTS:   max_req_q <= cfg_wdata_i;
          CFG_WINDOW_SECONDS: win_sec_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    now_q    <= now_d;
    m_data_q <= m_data_d;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the per-user fixed-window rate limiter.
module tb_top;
  import pfwrl_pkg::*;

  typedef struct packed {
    logic        allow;
    logic [31:0] window_count;
    logic        untracked;
  } verdict_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  // shadow of the user table and the limit registers
  key_t        tbl_key   [TABLE_ENTRIES];
  logic [31:0] tbl_count [TABLE_ENTRIES];
  logic [31:0] tbl_start [TABLE_ENTRIES];
  int unsigned tbl_used   = 0;
  logic [31:0] lim_max    = MAX_REQ_RST;
  logic [31:0] lim_window = WIN_SEC_RST;

  verdict_t pending_verdicts[$];
  int       fail_count = 0;
  bit       idle_on    = 1'b0;
  int       sink_hold  = 0;

  per_user_fixed_window_rate_limiter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic bit key_tracked(logic [63:0] k);
    for (int i = 0; i < tbl_used; i++)
      if (tbl_key[i] == k[KEY_BITS-1:0]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [63:0] fresh_key();
    logic [63:0] k;
    k = {$urandom, $urandom};
    while (key_tracked(k)) k = {$urandom, $urandom};
    return k;
  endfunction

  // first match in table order; absent keys appended while space remains
  function automatic verdict_t predict_verdict(logic [63:0] key_in, logic present,
                                               logic [31:0] now);
    key_t        k;
    int          slot;
    logic [31:0] elapsed;
    verdict_t    v;
    k    = present ? key_in[KEY_BITS-1:0] : RESERVED_KEY[KEY_BITS-1:0];
    slot = -1;
    for (int i = 0; i < tbl_used; i++)
      if (slot < 0 && tbl_key[i] == k) slot = i;
    if (slot < 0) begin
      if (tbl_used >= TABLE_ENTRIES) begin
        v.allow        = 1'b1;
        v.window_count = '0;
        v.untracked    = 1'b1;
        return v;
      end
      slot            = tbl_used;
      tbl_used++;
      tbl_key[slot]   = k;
      tbl_count[slot] = '0;
      tbl_start[slot] = now;
    end
    elapsed = now - tbl_start[slot];
    if (elapsed >= lim_window) begin
      tbl_count[slot] = '0;
      tbl_start[slot] = now;
    end
    if (tbl_count[slot] != COUNT_MAX) tbl_count[slot] = tbl_count[slot] + 32'd1;
    v.allow        = (tbl_count[slot] <= lim_max);
    v.window_count = tbl_count[slot];
    v.untracked    = 1'b0;
    return v;
  endfunction

  task automatic issue_request(logic [63:0] key, logic present, logic [31:0] now);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, key};
    s_axis_tuser  <= present;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_verdicts.push_back(predict_verdict(key, present, now));
  endtask

  task automatic drain_pending();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (addr == CFG_MAX_REQUESTS) lim_max = value;
    else if (addr == CFG_WINDOW_SECONDS) lim_window = value;
    @(posedge clk_i);
  endtask

  task automatic set_limits(logic [31:0] max_req, logic [31:0] win_sec);
    drain_pending();
    write_limit_reg(CFG_MAX_REQUESTS, max_req);
    write_limit_reg(CFG_WINDOW_SECONDS, win_sec);
  endtask

  // reset limits of 1000 requests per 60 s, reserved key sharing, window edges
  task automatic test_reset_defaults();
    issue_request(64'h0, 1'b1, 32'h0);
    issue_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    issue_request({$urandom, $urandom}, 1'b0, 32'd5);
    issue_request(RESERVED_KEY, 1'b1, 32'd6);
    issue_request(64'h0, 1'b1, 32'd59);
    issue_request(64'h0, 1'b1, 32'd60);
    issue_request(64'h0, 1'b1, 32'd30);  // time going backwards
  endtask

  task automatic test_limit_and_window();
    set_limits(32'd2, 32'd10);
    repeat (3) issue_request(64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 32'd100);
    issue_request(64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 32'd109);
    issue_request(64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 32'd110);
  endtask

  task automatic test_zero_window();
    set_limits(32'd0, 32'd0);
    repeat (2) issue_request(64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 32'd7);
    issue_request(64'h1234_5678_9ABC_DEF0, 1'b0, 32'd7);
  endtask

  task automatic test_extreme_limits();
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(64'h0F0F_F0F0_0F0F_F0F0, 1'b1, 32'd1000);
    issue_request(64'h0F0F_F0F0_0F0F_F0F0, 1'b1, 32'd999);   // difference is all ones
    issue_request(64'h0F0F_F0F0_0F0F_F0F0, 1'b1, 32'd5);
  endtask

  task automatic test_random_traffic();
    logic [63:0] pool [48];
    logic [31:0] now;
    int          r;
    logic [63:0] key;
    logic        present;
    pool[0] = RESERVED_KEY;
    pool[1] = 64'h0;
    pool[2] = 64'hFFFF_FFFF_FFFF_FFFF;
    for (int i = 3; i < 48; i++) pool[i] = {$urandom, $urandom};
    now = $urandom;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 6)
        0: set_limits(MAX_REQ_RST, WIN_SEC_RST);
        1: set_limits(32'd0, 32'd0);
        2: set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: set_limits($urandom_range(1, 6), $urandom_range(2, 30));
        4: set_limits($urandom_range(0, 3), 32'd1);
        default: set_limits($urandom, $urandom);
      endcase
      idle_on = (phase % 4 != 3);
      for (int n = 0; n < 130; n++) begin
        r = $urandom_range(0, 99);
        if (r < 50) now = now;
        else if (r < 80) now = now + $urandom_range(1, 4);
        else if (r < 92) now = now + $urandom_range(5, 100);
        else if (r < 96) now = now - $urandom_range(1, 50);
        else now = $urandom;
        // a few hot users so that limits and window restarts are reached
        key     = pool[($urandom_range(0, 99) < 80) ? $urandom_range(0, 7)
                                                    : $urandom_range(0, 47)];
        present = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          key     = {$urandom, $urandom};
          present = 1'b0;
        end
        issue_request(key, present, now);
      end
    end
  endtask

  // runs last: once the table is full it stays full
  task automatic test_table_full();
    logic [31:0] now;
    logic [63:0] key;
    set_limits(32'd5, 32'd100);
    idle_on = 1'b1;
    now     = $urandom;
    while (tbl_used < TABLE_ENTRIES) begin
      now = now + $urandom_range(0, 3);
      issue_request(fresh_key(), 1'b1, now);
    end
    for (int n = 0; n < 120; n++) begin
      now = now + $urandom_range(0, 20);
      if ($urandom_range(0, 1) == 0) begin
        issue_request(fresh_key(), 1'b1, now);
      end else if ($urandom_range(0, 7) == 0) begin
        issue_request({$urandom, $urandom}, 1'b0, now);
      end else begin
        key = {32'h0, 32'h0};
        key[KEY_BITS-1:0] = tbl_key[$urandom_range(0, TABLE_ENTRIES - 1)];
        issue_request(key, 1'b1, now);
      end
    end
  endtask

  // response-side backpressure
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (idle_on && $urandom_range(0, 2) == 0) begin
      sink_hold     <= gap_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no request pending: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.allow) begin
          $error("allow: expected %0d, got %0d", want.allow, m_axis_tdata[0]);
          fail_count++;
        end
        if (m_axis_tdata[32:1] !== want.window_count) begin
          $error("window_count: expected %0d, got %0d", want.window_count,
                 m_axis_tdata[32:1]);
          fail_count++;
        end
        if (m_axis_tdata[33] !== want.untracked) begin
          $error("untracked: expected %0d, got %0d", want.untracked, m_axis_tdata[33]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_limit_and_window();
    test_zero_window();
    test_extreme_limits();
    test_random_traffic();
    test_table_full();
    drain_pending();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
